### src/assert_macros.svh
// Assertion macros shared by the bit buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define MBB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked through reset as well.
`define MBB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/mbb_pkg.sv
// Package with sizes, codes and shared types of the MSB-first bit buffer.
package mbb_pkg;

   localparam int STORE_BYTES = 4096;
   localparam int WORD_BITS   = 64;
   localparam int STORE_WORDS = STORE_BYTES / 8;
   localparam int BANK_DEPTH  = STORE_WORDS / 2;
   localparam int BANK_AW     = $clog2(BANK_DEPTH);
   localparam int RAW_CAP     = STORE_BYTES * 8;
   localparam logic [16:0] CAP_BITS = 17'((RAW_CAP > 65535) ? 65535 : RAW_CAP);

   localparam logic [2:0] OP_APPEND    = 3'd0;
   localparam logic [2:0] OP_READ_NEXT = 3'd1;
   localparam logic [2:0] OP_READ_AT   = 3'd2;
   localparam logic [2:0] OP_SEEK      = 3'd3;
   localparam logic [2:0] OP_CLEAR     = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_BEYOND   = 2'd2;

   typedef struct packed {
      logic [5:0]  bit_in_word;
      logic [6:0]  count;
      logic [63:0] data;
   } field_ctl_type;

endpackage

### src/mbb_bank_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module mbb_bank_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/mbb_field.sv
// Field aligner: extracts a field from two adjacent words and merges a new field into them.
module mbb_field (
   input  mbb_pkg::field_ctl_type ctl,
   input  logic [63:0]            word_lo,
   input  logic [63:0]            word_hi,
   output logic [63:0]            field_value,
   output logic [63:0]            merged_lo,
   output logic [63:0]            merged_hi
);

   logic [127:0] pair;
   logic [127:0] field_mask;
   logic [127:0] field_ins;
   logic [127:0] merged;
   logic [127:0] shifted;
   logic [63:0]  count_mask;
   logic [7:0]   shift;

   always_comb begin
      pair = {word_lo, word_hi};
      if (ctl.count[6]) begin
         count_mask = '1;
      end else begin
         count_mask = (64'd1 << ctl.count[5:0]) - 64'd1;
      end
      // The field's last bit sits this far above the low end of the word pair.
      shift = 8'd128 - {2'b00, ctl.bit_in_word} - {1'b0, ctl.count};
      shifted = pair >> shift;
      field_value = shifted[63:0] & count_mask;
      field_mask = {64'd0, count_mask} << shift;
      field_ins = {64'd0, ctl.data & count_mask} << shift;
      merged = (pair & ~field_mask) | field_ins;
      merged_lo = merged[127:64];
      merged_hi = merged[63:0];
   end

endmodule

### src/msb_first_bit_buffer.sv
// Top level of the MSB-first bit buffer over two banks of 64-bit words.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------------
//   request  | start, busy        | req_operation, req_data_bits, req_bit_count,
//            |                    | req_bit_offset
//   response | rsp_valid (strobe) | rsp_read_value, rsp_cursor_position,
//            |                    | rsp_fill_level, rsp_status
//
// Each item reads the word pair from the even and odd banks in the accept cycle and
// modifies and writes it back in the next, so busy is high for one cycle.
// The response strobe rises as busy falls and lasts one cycle; the next item may be
// accepted at the edge that ends it.
// Reset clears both pointers; the memory content is not cleared and needs no sweep.
// The receiver cannot stall, so a response is shown for exactly one cycle.
`include "assert_macros.svh"

module msb_first_bit_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [63:0] req_data_bits,
   input  logic [6:0]  req_bit_count,
   input  logic [15:0] req_bit_offset,
   output logic        rsp_valid,
   output logic [63:0] rsp_read_value,
   output logic [15:0] rsp_cursor_position,
   output logic [15:0] rsp_fill_level,
   output logic [1:0]  rsp_status
);

   localparam int AW = mbb_pkg::BANK_AW;

   logic        busy_ff, busy_in;
   logic        valid_ff, valid_in;
   logic [15:0] wp_ff, wp_in;
   logic [15:0] rc_ff, rc_in;
   logic [2:0]  op_ff;
   logic [6:0]  count_ff;
   logic [15:0] pos_ff;
   logic [15:0] offset_ff;
   logic [63:0] data_ff;
   logic [AW-1:0] even_addr_ff;
   logic [AW-1:0] odd_addr_ff;
   logic [63:0] value_ff, value_in;
   logic [1:0]  status_ff, status_in;

   logic        accept;
   logic [6:0]  count_sel;
   logic [15:0] pos_sel;
   logic [15:0] even_addr_full;
   logic [15:0] odd_addr_full;
   logic [63:0] even_q, odd_q;
   logic [63:0] word_lo, word_hi;
   logic [63:0] field_value, merged_lo, merged_hi;
   logic        read_ok;
   logic        append_ok;
   logic        wr_en;
   logic [63:0] even_wdata, odd_wdata;
   mbb_pkg::field_ctl_type ctl;

   assign accept = start && !busy_ff;

   always_comb begin
      count_sel = (req_bit_count > 7'd64) ? 7'd64 : req_bit_count;
      priority if (req_operation == mbb_pkg::OP_READ_AT) begin
         pos_sel = req_bit_offset;
      end else if (req_operation == mbb_pkg::OP_READ_NEXT) begin
         pos_sel = rc_ff;
      end else begin
         pos_sel = wp_ff;
      end
      // Word w lies in bank w[0]; the pair w, w+1 always uses one entry of each bank.
      even_addr_full = 16'(({1'b0, pos_sel[15:6]} + 11'd1) >> 1);
      odd_addr_full = {7'd0, pos_sel[15:7]};
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_operation;
         count_ff <= count_sel;
         pos_ff <= pos_sel;
         offset_ff <= req_bit_offset;
         data_ff <= req_data_bits;
         even_addr_ff <= even_addr_full[AW-1:0];
         odd_addr_ff <= odd_addr_full[AW-1:0];
      end
   end

   mbb_bank_ram #(
      .WIDTH(mbb_pkg::WORD_BITS),
      .DEPTH(mbb_pkg::BANK_DEPTH)
   ) u_even_bank (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(even_addr_ff),
      .wr_data(even_wdata),
      .rd_en  (accept),
      .rd_addr(even_addr_full[AW-1:0]),
      .rd_data(even_q)
   );

   mbb_bank_ram #(
      .WIDTH(mbb_pkg::WORD_BITS),
      .DEPTH(mbb_pkg::BANK_DEPTH)
   ) u_odd_bank (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(odd_addr_ff),
      .wr_data(odd_wdata),
      .rd_en  (accept),
      .rd_addr(odd_addr_full[AW-1:0]),
      .rd_data(odd_q)
   );

   always_comb begin
      word_lo = pos_ff[6] ? odd_q : even_q;
      word_hi = pos_ff[6] ? even_q : odd_q;
      ctl.bit_in_word = pos_ff[5:0];
      ctl.count = count_ff;
      ctl.data = data_ff;
   end

   mbb_field u_field (
      .ctl        (ctl),
      .word_lo    (word_lo),
      .word_hi    (word_hi),
      .field_value(field_value),
      .merged_lo  (merged_lo),
      .merged_hi  (merged_hi)
   );

   always_comb begin
      read_ok = ({1'b0, pos_ff} + {10'd0, count_ff}) <= {1'b0, wp_ff};
      append_ok = ({1'b0, wp_ff} + {10'd0, count_ff}) <= mbb_pkg::CAP_BITS;
      wr_en = busy_ff && (op_ff == mbb_pkg::OP_APPEND) && append_ok;
      even_wdata = pos_ff[6] ? merged_hi : merged_lo;
      odd_wdata = pos_ff[6] ? merged_lo : merged_hi;

      busy_in = accept;
      valid_in = busy_ff;
      wp_in = wp_ff;
      rc_in = rc_ff;
      value_in = '0;
      status_in = mbb_pkg::ST_OK;
      if (busy_ff) begin
         unique case (op_ff)
            mbb_pkg::OP_APPEND: begin
               if (append_ok) begin
                  wp_in = wp_ff + {9'd0, count_ff};
               end else begin
                  status_in = mbb_pkg::ST_OVERFLOW;
               end
            end
            mbb_pkg::OP_READ_NEXT: begin
               if (read_ok) begin
                  value_in = field_value;
                  rc_in = rc_ff + {9'd0, count_ff};
               end else begin
                  status_in = mbb_pkg::ST_BEYOND;
               end
            end
            mbb_pkg::OP_READ_AT: begin
               if (read_ok) begin
                  value_in = field_value;
               end else begin
                  status_in = mbb_pkg::ST_BEYOND;
               end
            end
            mbb_pkg::OP_SEEK: begin
               rc_in = offset_ff;
            end
            mbb_pkg::OP_CLEAR: begin
               wp_in = '0;
               rc_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         valid_ff <= 1'b0;
         wp_ff <= '0;
         rc_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         valid_ff <= valid_in;
         wp_ff <= wp_in;
         rc_ff <= rc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         value_ff <= value_in;
         status_ff <= status_in;
      end
   end

   assign busy = busy_ff;
   assign rsp_valid = valid_ff;
   assign rsp_read_value = value_ff;
   assign rsp_status = status_ff;
   assign rsp_cursor_position = rc_ff;
   assign rsp_fill_level = wp_ff;

   `MBB_ASSERT(a_accept_sets_busy, clock, reset, (start && !busy) |=> busy, "accept without busy")
   `MBB_ASSERT(a_busy_then_rsp, clock, reset, busy |=> (rsp_valid && !busy), "missing response")
   `MBB_ASSERT(a_fill_in_range, clock, reset, ({1'b0, wp_ff} <= mbb_pkg::CAP_BITS), "fill level")

endmodule
